FILE: sv/pd_steering_speed_control_unit_defines.svh
// Assertion macros used by the steering/speed control sequencer
`ifndef PD_STEERING_SPEED_CONTROL_UNIT_DEFINES_SVH
`define PD_STEERING_SPEED_CONTROL_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define PDSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/pdsc_pkg.sv
// ----------------------------------------------------------------------------
// pdsc_pkg
// Types, constants and helper functions of the PD steering and speed control.
// ----------------------------------------------------------------------------
package pdsc_pkg;

    localparam int WHEELBASE_Q12_DEF    = 1925;
    localparam int FRONT_OFFSET_Q12_DEF = 686;
    localparam int CORDIC_ITERS_DEF     = 14;

    localparam int SQRT_STEPS = 16;

    localparam logic signed [15:0] BRAKE_SPEED  = -16'sd4096;
    localparam logic signed [15:0] STOP_THRESH  = 16'sd410;
    localparam logic signed [35:0] PD_ROUND     = 36'sd2048;
    localparam logic signed [19:0] ANGLE_ROUND  = 20'sd8;

    localparam logic [15:0] RST_GAIN_P    = 16'd4096;
    localparam logic [15:0] RST_GAIN_D    = 16'd410;
    localparam logic [14:0] RST_ERR_LIMIT = 15'd410;
    localparam logic [14:0] RST_LOOKAHEAD = 15'd4096;
    localparam logic [15:0] RST_NEUTRAL   = 16'd0;
    localparam logic [14:0] RST_TARGET    = 15'd4096;
    localparam logic [14:0] RST_SPD_STEP  = 15'd205;
    localparam logic        RST_SMOOTH    = 1'b1;

    typedef enum logic [2:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_D    = 3'd1,
        CFG_ERR_LIMIT = 3'd2,
        CFG_LOOKAHEAD = 3'd3,
        CFG_NEUTRAL   = 3'd4,
        CFG_TARGET    = 3'd5,
        CFG_SPD_STEP  = 3'd6,
        CFG_SMOOTH    = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQX,
        ST_SQY,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_NUM,
        ST_DEN_MUL,
        ST_DEN_ADD,
        ST_COR_INIT,
        ST_COR,
        ST_ERR,
        ST_PD_P,
        ST_PD_D,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQX,
        OP_SQY,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_NUM,
        OP_DEN_MUL,
        OP_DEN_ADD,
        OP_COR_INIT,
        OP_COR_STEP,
        OP_ERR,
        OP_PD_P,
        OP_PD_D,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic active;
        logic sqrt_last;
        logic cor_last;
        logic out_pending;
    } sts_t;

    // arctangent of 2^-i in Q16
    function automatic logic [16:0] atan_q16(input logic [3:0] idx);
        logic [16:0] v;
        begin
            unique case (idx)
                4'd0:    v = 17'd51472;
                4'd1:    v = 17'd30386;
                4'd2:    v = 17'd16055;
                4'd3:    v = 17'd8150;
                4'd4:    v = 17'd4091;
                4'd5:    v = 17'd2047;
                4'd6:    v = 17'd1024;
                4'd7:    v = 17'd512;
                4'd8:    v = 17'd256;
                4'd9:    v = 17'd128;
                4'd10:   v = 17'd64;
                4'd11:   v = 17'd32;
                4'd12:   v = 17'd16;
                4'd13:   v = 17'd8;
                4'd14:   v = 17'd4;
                default: v = 17'd2;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        logic signed [15:0] r;
        begin
            if (v > 36'sd32767)
                r = 16'sh7fff;
            else if (v < -36'sd32768)
                r = 16'sh8000;
            else
                r = v[15:0];
            return r;
        end
    endfunction

endpackage

FILE: sv/pdsc_in_if.sv
// ----------------------------------------------------------------------------
// pdsc_in_if
// Input channel: one waypoint and flag set per beat.
// ----------------------------------------------------------------------------
interface pdsc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] way_x;
    logic signed [15:0] way_y;
    logic               goal_active;
    logic               way_found;
    logic               at_goal;
    logic signed [15:0] measured_speed;

    modport source (output valid, way_x, way_y, goal_active, way_found, at_goal,
                    measured_speed, input ready);
    modport sink (input valid, way_x, way_y, goal_active, way_found, at_goal,
                  measured_speed, output ready);
endinterface

FILE: sv/pdsc_out_if.sv
// ----------------------------------------------------------------------------
// pdsc_out_if
// Output channel: steering, speed and heading error per beat.
// ----------------------------------------------------------------------------
interface pdsc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] steer_cmd;
    logic signed [15:0] speed_cmd;
    logic signed [15:0] heading_error;

    modport source (output valid, steer_cmd, speed_cmd, heading_error, input ready);
    modport sink (input valid, steer_cmd, speed_cmd, heading_error, output ready);
endinterface

FILE: sv/pdsc_ctrl.sv
// ----------------------------------------------------------------------------
// pdsc_ctrl
// Sequencer: steps the datapath through square root, CORDIC and PD phases.
// ----------------------------------------------------------------------------
`include "pd_steering_speed_control_unit_defines.svh"

module pdsc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output pdsc_pkg::cmd_t  cmd,
    input  pdsc_pkg::sts_t  sts
);

    pdsc_pkg::state_t state_reg;
    pdsc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= pdsc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = pdsc_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            pdsc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = pdsc_pkg::OP_LOAD;
                    state_next = pdsc_pkg::ST_CHECK;
                end
            end
            pdsc_pkg::ST_CHECK:
                state_next = sts.active ? pdsc_pkg::ST_SQX : pdsc_pkg::ST_FINISH;
            pdsc_pkg::ST_SQX:
            begin
                cmd.op     = pdsc_pkg::OP_SQX;
                state_next = pdsc_pkg::ST_SQY;
            end
            pdsc_pkg::ST_SQY:
            begin
                cmd.op     = pdsc_pkg::OP_SQY;
                state_next = pdsc_pkg::ST_SQRT_INIT;
            end
            pdsc_pkg::ST_SQRT_INIT:
            begin
                cmd.op     = pdsc_pkg::OP_SQRT_INIT;
                state_next = pdsc_pkg::ST_SQRT;
            end
            pdsc_pkg::ST_SQRT:
            begin
                cmd.op = pdsc_pkg::OP_SQRT_STEP;
                if (sts.sqrt_last)
                    state_next = pdsc_pkg::ST_NUM;
            end
            pdsc_pkg::ST_NUM:
            begin
                cmd.op     = pdsc_pkg::OP_NUM;
                state_next = pdsc_pkg::ST_DEN_MUL;
            end
            pdsc_pkg::ST_DEN_MUL:
            begin
                cmd.op     = pdsc_pkg::OP_DEN_MUL;
                state_next = pdsc_pkg::ST_DEN_ADD;
            end
            pdsc_pkg::ST_DEN_ADD:
            begin
                cmd.op     = pdsc_pkg::OP_DEN_ADD;
                state_next = pdsc_pkg::ST_COR_INIT;
            end
            pdsc_pkg::ST_COR_INIT:
            begin
                cmd.op     = pdsc_pkg::OP_COR_INIT;
                state_next = pdsc_pkg::ST_COR;
            end
            pdsc_pkg::ST_COR:
            begin
                cmd.op = pdsc_pkg::OP_COR_STEP;
                if (sts.cor_last)
                    state_next = pdsc_pkg::ST_ERR;
            end
            pdsc_pkg::ST_ERR:
            begin
                cmd.op     = pdsc_pkg::OP_ERR;
                state_next = pdsc_pkg::ST_PD_P;
            end
            pdsc_pkg::ST_PD_P:
            begin
                cmd.op     = pdsc_pkg::OP_PD_P;
                state_next = pdsc_pkg::ST_PD_D;
            end
            pdsc_pkg::ST_PD_D:
            begin
                cmd.op     = pdsc_pkg::OP_PD_D;
                state_next = pdsc_pkg::ST_FINISH;
            end
            pdsc_pkg::ST_FINISH:
            begin
                // wait until the output slot is free
                if (!sts.out_pending)
                begin
                    cmd.op     = pdsc_pkg::OP_FINISH;
                    state_next = pdsc_pkg::ST_IDLE;
                end
            end
            default:
                state_next = pdsc_pkg::ST_IDLE;
        endcase
    end

    `PDSC_ASSERT_NOW(a_finish_slot_free, cmd.op == pdsc_pkg::OP_FINISH, !sts.out_pending, "result written over a pending beat")
    `PDSC_ASSERT_NEXT(a_idle_tick_skips, (state_reg == pdsc_pkg::ST_CHECK) && !sts.active, state_reg == pdsc_pkg::ST_FINISH, "inactive tick did not go to finish")
    `PDSC_ASSERT_NEXT(a_cordic_ends, (state_reg == pdsc_pkg::ST_COR) && sts.cor_last, state_reg == pdsc_pkg::ST_ERR, "CORDIC phase did not end on last iteration")

endmodule

FILE: sv/pdsc_datapath.sv
// ----------------------------------------------------------------------------
// pdsc_datapath
// Config registers, square root, CORDIC arctangent, PD law and held commands.
// ----------------------------------------------------------------------------
module pdsc_datapath #(
    parameter int WHEELBASE_Q12    = pdsc_pkg::WHEELBASE_Q12_DEF,
    parameter int FRONT_OFFSET_Q12 = pdsc_pkg::FRONT_OFFSET_Q12_DEF,
    parameter int CORDIC_ITERS     = pdsc_pkg::CORDIC_ITERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pdsc_pkg::cmd_t     cmd,
    output pdsc_pkg::sts_t     sts,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [15:0]        cfg_data,
    input  logic signed [15:0] way_x,
    input  logic signed [15:0] way_y,
    input  logic               goal_active,
    input  logic               way_found,
    input  logic               at_goal,
    input  logic signed [15:0] measured_speed,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] steer_cmd,
    output logic signed [15:0] speed_cmd,
    output logic signed [15:0] heading_error
);

    localparam logic signed [17:0] NUM_K  = 18'(2 * WHEELBASE_Q12);
    localparam logic signed [17:0] FO_K   = 18'(2 * FRONT_OFFSET_Q12);
    localparam logic [3:0]         COR_LAST  = 4'(CORDIC_ITERS - 1);
    localparam logic [3:0]         SQRT_LAST = 4'(pdsc_pkg::SQRT_STEPS - 1);

    // configuration
    logic [15:0]        gain_p_reg, gain_d_reg;
    logic [14:0]        err_limit_reg, lookahead_reg, target_reg, spd_step_reg;
    logic signed [15:0] neutral_reg;
    logic               smooth_reg;

    // control state
    logic               active_reg, active_next;
    logic               at_goal_reg, at_goal_next;
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] prev_err_reg, prev_err_next;
    logic signed [15:0] held_speed_reg, held_speed_next;
    logic signed [15:0] held_steer_reg, held_steer_next;
    logic [3:0]         iter_reg, iter_next;

    // payload
    logic signed [15:0] wx_reg, wx_next;
    logic signed [15:0] wy_reg, wy_next;
    logic signed [15:0] meas_reg, meas_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        res_reg, res_next;
    logic [31:0]        bit_reg, bit_next;
    logic signed [32:0] num_reg, num_next;
    logic signed [33:0] den_reg, den_next;
    logic signed [35:0] cx_reg, cx_next;
    logic signed [35:0] cy_reg, cy_next;
    logic signed [19:0] cz_reg, cz_next;
    logic signed [15:0] err_reg, err_next;
    logic signed [16:0] derr_reg, derr_next;
    logic signed [35:0] pd_reg, pd_next;
    logic signed [15:0] o_steer_reg, o_steer_next;
    logic signed [15:0] o_speed_reg, o_speed_next;
    logic signed [15:0] o_herr_reg, o_herr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= pdsc_pkg::RST_GAIN_P;
            gain_d_reg    <= pdsc_pkg::RST_GAIN_D;
            err_limit_reg <= pdsc_pkg::RST_ERR_LIMIT;
            lookahead_reg <= pdsc_pkg::RST_LOOKAHEAD;
            neutral_reg   <= pdsc_pkg::RST_NEUTRAL;
            target_reg    <= pdsc_pkg::RST_TARGET;
            spd_step_reg  <= pdsc_pkg::RST_SPD_STEP;
            smooth_reg    <= pdsc_pkg::RST_SMOOTH;
        end
        else if (cfg_we)
        begin
            unique case (pdsc_pkg::cfg_idx_t'(cfg_idx))
                pdsc_pkg::CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                pdsc_pkg::CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                pdsc_pkg::CFG_ERR_LIMIT: err_limit_reg <= cfg_data[14:0];
                pdsc_pkg::CFG_LOOKAHEAD: lookahead_reg <= cfg_data[14:0];
                pdsc_pkg::CFG_NEUTRAL:   neutral_reg   <= cfg_data;
                pdsc_pkg::CFG_TARGET:    target_reg    <= cfg_data[14:0];
                pdsc_pkg::CFG_SPD_STEP:  spd_step_reg  <= cfg_data[14:0];
                pdsc_pkg::CFG_SMOOTH:    smooth_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            at_goal_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_err_reg   <= '0;
            held_speed_reg <= '0;
            held_steer_reg <= '0;
            iter_reg       <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            at_goal_reg    <= at_goal_next;
            out_valid_reg  <= out_valid_next;
            prev_err_reg   <= prev_err_next;
            held_speed_reg <= held_speed_next;
            held_steer_reg <= held_steer_next;
            iter_reg       <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wx_reg      <= wx_next;
        wy_reg      <= wy_next;
        meas_reg    <= meas_next;
        rem_reg     <= rem_next;
        res_reg     <= res_next;
        bit_reg     <= bit_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        cz_reg      <= cz_next;
        err_reg     <= err_next;
        derr_reg    <= derr_next;
        pd_reg      <= pd_next;
        o_steer_reg <= o_steer_next;
        o_speed_reg <= o_speed_next;
        o_herr_reg  <= o_herr_next;
    end

    always_comb
    begin
        logic [31:0]        trial;
        logic signed [35:0] xs, ys;
        logic signed [19:0] ang;
        logic signed [15:0] err_raw;
        logic signed [16:0] derr_raw, lim_s, derr_c;
        logic signed [17:0] err_sum;
        logic signed [23:0] pd_rnd;
        logic signed [17:0] spd_sum;
        logic signed [15:0] steer_new, speed_new, perr_new;

        active_next     = active_reg;
        at_goal_next    = at_goal_reg;
        out_valid_next  = out_valid_reg;
        prev_err_next   = prev_err_reg;
        held_speed_next = held_speed_reg;
        held_steer_next = held_steer_reg;
        iter_next       = iter_reg;
        wx_next         = wx_reg;
        wy_next         = wy_reg;
        meas_next       = meas_reg;
        rem_next        = rem_reg;
        res_next        = res_reg;
        bit_next        = bit_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        err_next        = err_reg;
        derr_next       = derr_reg;
        pd_next         = pd_reg;
        o_steer_next    = o_steer_reg;
        o_speed_next    = o_speed_reg;
        o_herr_next     = o_herr_reg;

        trial     = res_reg + bit_reg;
        xs        = cx_reg >>> iter_reg;
        ys        = cy_reg >>> iter_reg;
        ang       = 20'($signed({1'b0, pdsc_pkg::atan_q16(iter_reg)}));
        err_raw   = (wy_reg == 16'sd0) ? 16'sd0 : 16'((cz_reg + pdsc_pkg::ANGLE_ROUND) >>> 4);
        derr_raw  = 17'(err_raw) - 17'(prev_err_reg);
        lim_s     = $signed({2'b00, err_limit_reg});
        derr_c    = (derr_raw > lim_s) ? lim_s : ((derr_raw < -lim_s) ? -lim_s : derr_raw);
        err_sum   = 18'(prev_err_reg) + 18'(derr_c);
        pd_rnd    = 24'((pd_reg + pdsc_pkg::PD_ROUND) >>> 12);
        spd_sum   = 18'(held_speed_reg) + $signed({3'b000, spd_step_reg});
        steer_new = held_steer_reg;
        speed_new = held_speed_reg;
        perr_new  = prev_err_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (cmd.op)
            pdsc_pkg::OP_LOAD:
            begin
                wx_next      = way_x;
                wy_next      = way_y;
                meas_next    = measured_speed;
                at_goal_next = at_goal;
                active_next  = goal_active && way_found && !at_goal;
            end
            pdsc_pkg::OP_SQX:
                rem_next = 32'(wx_reg * wx_reg);
            pdsc_pkg::OP_SQY:
                rem_next = rem_reg + 32'(wy_reg * wy_reg);
            pdsc_pkg::OP_SQRT_INIT:
            begin
                res_next  = '0;
                bit_next  = 32'h4000_0000;
                iter_next = '0;
            end
            pdsc_pkg::OP_SQRT_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                    res_next = res_reg >> 1;
                bit_next  = bit_reg >> 2;
                iter_next = iter_reg + 4'd1;
            end
            pdsc_pkg::OP_NUM:
                num_next = 33'(NUM_K * wy_reg);
            pdsc_pkg::OP_DEN_MUL:
                den_next = $signed({3'b000, 31'(lookahead_reg * res_reg[15:0])});
            pdsc_pkg::OP_DEN_ADD:
                den_next = den_reg + 34'(FO_K * wx_reg);
            pdsc_pkg::OP_COR_INIT:
            begin
                // fold a negative denominator into the right half plane
                if (den_reg < 0)
                begin
                    cx_next = -36'(den_reg);
                    cy_next = -36'(num_reg);
                end
                else
                begin
                    cx_next = 36'(den_reg);
                    cy_next = 36'(num_reg);
                end
                cz_next   = '0;
                iter_next = '0;
            end
            pdsc_pkg::OP_COR_STEP:
            begin
                if (cy_reg > 0)
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    cz_next = cz_reg + ang;
                end
                else
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    cz_next = cz_reg - ang;
                end
                iter_next = iter_reg + 4'd1;
            end
            pdsc_pkg::OP_ERR:
            begin
                if (err_limit_reg != '0)
                begin
                    derr_next = derr_c;
                    err_next  = pdsc_pkg::sat16(36'(err_sum));
                end
                else
                begin
                    derr_next = derr_raw;
                    err_next  = err_raw;
                end
            end
            pdsc_pkg::OP_PD_P:
                pd_next = 36'($signed({1'b0, gain_p_reg}) * err_reg);
            pdsc_pkg::OP_PD_D:
                pd_next = pd_reg + 36'($signed({1'b0, gain_d_reg}) * derr_reg);
            pdsc_pkg::OP_FINISH:
            begin
                if (active_reg)
                begin
                    steer_new = pdsc_pkg::sat16(36'(neutral_reg) + 36'(pd_rnd));
                    perr_new  = err_reg;
                    if (smooth_reg)
                        speed_new = (spd_sum < $signed({3'b000, target_reg})) ?
                                    spd_sum[15:0] : {1'b0, target_reg};
                    else
                        speed_new = {1'b0, target_reg};
                end
                if (at_goal_reg)
                begin
                    speed_new = (meas_reg >= pdsc_pkg::STOP_THRESH) ?
                                pdsc_pkg::BRAKE_SPEED : 16'sd0;
                    steer_new = neutral_reg;
                end
                held_steer_next = steer_new;
                held_speed_next = speed_new;
                prev_err_next   = perr_new;
                o_steer_next    = steer_new;
                o_speed_next    = speed_new;
                o_herr_next     = perr_new;
                out_valid_next  = 1'b1;
            end
            default: ;
        endcase
    end

    assign sts.active      = active_reg;
    assign sts.sqrt_last   = (iter_reg == SQRT_LAST);
    assign sts.cor_last    = (iter_reg == COR_LAST);
    assign sts.out_pending = out_valid_reg && !out_ready;

    assign out_valid     = out_valid_reg;
    assign steer_cmd     = o_steer_reg;
    assign speed_cmd     = o_speed_reg;
    assign heading_error = o_herr_reg;

endmodule

FILE: sv/pd_steering_speed_control_unit.sv
// ----------------------------------------------------------------------------
// pd_steering_speed_control_unit
// Pure-pursuit PD steering and speed command generator, Q4.12.
// Each steering tick runs a 16-step square root and then one CORDIC iteration
//   per cycle; a tick without steering update skips both.
// A new input beat is taken only after the last result has been written to the
//   output register; a stalled result holds off the input.
// Reset: async active low; registers to defaults, held commands and error to 0.
// ----------------------------------------------------------------------------
module pd_steering_speed_control_unit #(
    parameter int WHEELBASE_Q12    = pdsc_pkg::WHEELBASE_Q12_DEF,
    parameter int FRONT_OFFSET_Q12 = pdsc_pkg::FRONT_OFFSET_Q12_DEF,
    parameter int CORDIC_ITERS     = pdsc_pkg::CORDIC_ITERS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    pdsc_in_if.sink     in_ch,
    pdsc_out_if.source  out_ch
);

    pdsc_pkg::cmd_t cmd;
    pdsc_pkg::sts_t sts;

    pdsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    pdsc_datapath #(
        .WHEELBASE_Q12    (WHEELBASE_Q12),
        .FRONT_OFFSET_Q12 (FRONT_OFFSET_Q12),
        .CORDIC_ITERS     (CORDIC_ITERS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_data       (cfg_data),
        .way_x          (in_ch.way_x),
        .way_y          (in_ch.way_y),
        .goal_active    (in_ch.goal_active),
        .way_found      (in_ch.way_found),
        .at_goal        (in_ch.at_goal),
        .measured_speed (in_ch.measured_speed),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .steer_cmd      (out_ch.steer_cmd),
        .speed_cmd      (out_ch.speed_cmd),
        .heading_error  (out_ch.heading_error)
    );

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the pure-pursuit PD steering and speed controller.
// Directed ticks cover the extremes and corner cases. Random ticks follow,
// under several register settings and idle patterns. Every output beat is
// checked against a cycle-free predictor of the Q4.12 arithmetic.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic signed [15:0] wx;
        logic signed [15:0] wy;
        logic               goal_active;
        logic               way_found;
        logic               at_goal;
        logic signed [15:0] meas;
    } tick_t;

    typedef struct {
        logic signed [15:0] steer;
        logic signed [15:0] speed;
        logic signed [15:0] herr;
    } cmd_beat_t;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLDOFF_CYCLES = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [15:0] cfg_data;

    pdsc_in_if  in_ch ();
    pdsc_out_if out_ch ();

    pd_steering_speed_control_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_idx (cfg_idx),
        .cfg_data(cfg_data),
        .in_ch   (in_ch.sink),
        .out_ch  (out_ch.source)
    );

    tick_t     tick_q[$];
    cmd_beat_t cmd_q[$];
    tick_t     cur_tick;
    int        src_idle;
    int        snk_stall;
    int        holdoff_req;
    int        holdoff_seen;
    int        holdoff_cnt;
    int        quiet_cycles;
    int        n_fail;

    // predictor copy of registers and state
    longint m_gain_p, m_gain_d, m_lim, m_look, m_neutral, m_target, m_step, m_smooth;
    longint m_prev_err, m_speed, m_steer;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint clip16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res;
        longint bitv;
        res  = 0;
        bitv = longint'(1) << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_q12(longint num, longint den);
        longint x;
        longint y;
        longint z;
        longint nx;
        if (num == 0)
            return 0;
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        x = den;
        y = num;
        z = 0;
        for (int i = 0; i < pdsc_pkg::CORDIC_ITERS_DEF; i++)
        begin
            if (y > 0)
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(pdsc_pkg::atan_q16(i[3:0]));
            end
            else
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(pdsc_pkg::atan_q16(i[3:0]));
            end
            x = nx;
        end
        return (z + 8) >>> 4;
    endfunction

    // one control tick: update the predicted state and queue the command beat
    task automatic predict_tick(tick_t t);
        longint wx;
        longint wy;
        longint r;
        longint num;
        longint den;
        longint err;
        longint derr;
        longint pd;
        longint s;
        cmd_beat_t b;
        wx = longint'(t.wx);
        wy = longint'(t.wy);
        if (t.goal_active && t.way_found && !t.at_goal)
        begin
            r    = int_sqrt(wx * wx + wy * wy);
            num  = 2 * pdsc_pkg::WHEELBASE_Q12_DEF * wy;
            den  = m_look * r + 2 * pdsc_pkg::FRONT_OFFSET_Q12_DEF * wx;
            err  = atan_q12(num, den);
            derr = err - m_prev_err;
            if (m_lim > 0)
            begin
                if (derr > m_lim)
                    derr = m_lim;
                if (derr < -m_lim)
                    derr = -m_lim;
                err = clip16(m_prev_err + derr);
            end
            pd         = m_gain_p * err + m_gain_d * derr;
            m_steer    = clip16(m_neutral + ((pd + 2048) >>> 12));
            m_prev_err = err;
            if (m_smooth != 0)
            begin
                s       = m_speed + m_step;
                m_speed = (s < m_target) ? s : m_target;
            end
            else
                m_speed = m_target;
        end
        if (t.at_goal)
        begin
            m_speed = (t.meas >= 16'sd410) ? -4096 : 0;
            m_steer = m_neutral;
        end
        b.steer = m_steer[15:0];
        b.speed = m_speed[15:0];
        b.herr  = m_prev_err[15:0];
        cmd_q = {cmd_q, b};
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_tick(cur_tick);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (tick_q.size() > 0 && $urandom_range(99) >= src_idle)
                begin
                    cur_tick             = tick_q.pop_front();
                    in_ch.way_x          <= cur_tick.wx;
                    in_ch.way_y          <= cur_tick.wy;
                    in_ch.goal_active    <= cur_tick.goal_active;
                    in_ch.way_found      <= cur_tick.way_found;
                    in_ch.at_goal        <= cur_tick.at_goal;
                    in_ch.measured_speed <= cur_tick.meas;
                    in_ch.valid          <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // output monitor and ready generation
    always @(posedge clk or negedge rst_n)
    begin
        cmd_beat_t e;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            holdoff_cnt  <= 0;
            holdoff_seen <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (cmd_q.size() == 0)
                begin
                    $error("unexpected output beat");
                    n_fail++;
                end
                else
                begin
                    e = cmd_q.pop_front();
                    if (out_ch.steer_cmd !== e.steer)
                    begin
                        $error("steer_cmd: expected %0d, got %0d", e.steer, out_ch.steer_cmd);
                        n_fail++;
                    end
                    if (out_ch.speed_cmd !== e.speed)
                    begin
                        $error("speed_cmd: expected %0d, got %0d", e.speed, out_ch.speed_cmd);
                        n_fail++;
                    end
                    if (out_ch.heading_error !== e.herr)
                    begin
                        $error("heading_error: expected %0d, got %0d", e.herr,
                               out_ch.heading_error);
                        n_fail++;
                    end
                end
            end
            if (holdoff_req != holdoff_seen)
            begin
                holdoff_seen <= holdoff_req;
                holdoff_cnt  <= HOLDOFF_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (holdoff_cnt > 0)
            begin
                holdoff_cnt  <= holdoff_cnt - 1;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= snk_stall);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(pdsc_pkg::cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            pdsc_pkg::CFG_GAIN_P:    m_gain_p  = val;
            pdsc_pkg::CFG_GAIN_D:    m_gain_d  = val;
            pdsc_pkg::CFG_ERR_LIMIT: m_lim     = val[14:0];
            pdsc_pkg::CFG_LOOKAHEAD: m_look    = val[14:0];
            pdsc_pkg::CFG_NEUTRAL:   m_neutral = longint'($signed(val));
            pdsc_pkg::CFG_TARGET:    m_target  = val[14:0];
            pdsc_pkg::CFG_SPD_STEP:  m_step    = val[14:0];
            pdsc_pkg::CFG_SMOOTH:    m_smooth  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] gp, logic [15:0] gd, logic [15:0] lim,
                            logic [15:0] look, logic [15:0] neu, logic [15:0] tgt,
                            logic [15:0] stp, logic [15:0] smo);
        write_reg(pdsc_pkg::CFG_GAIN_P, gp);
        write_reg(pdsc_pkg::CFG_GAIN_D, gd);
        write_reg(pdsc_pkg::CFG_ERR_LIMIT, lim);
        write_reg(pdsc_pkg::CFG_LOOKAHEAD, look);
        write_reg(pdsc_pkg::CFG_NEUTRAL, neu);
        write_reg(pdsc_pkg::CFG_TARGET, tgt);
        write_reg(pdsc_pkg::CFG_SPD_STEP, stp);
        write_reg(pdsc_pkg::CFG_SMOOTH, smo);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (tick_q.size() > 0 || in_ch.valid || cmd_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] rand16();
        case ($urandom_range(5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(200)) - 100);
            3:       return 16'($urandom_range(16383));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_tick(logic [15:0] x, logic [15:0] y, logic ga, logic wf, logic ag,
                            logic [15:0] ms);
        tick_t t;
        t.wx          = x;
        t.wy          = y;
        t.goal_active = ga;
        t.way_found   = wf;
        t.at_goal     = ag;
        t.meas        = ms;
        tick_q = {tick_q, t};
    endtask

    task automatic add_random(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 72)
                add_tick(rand16(), rand16(), 1'b1, 1'b1, 1'b0, rand16());
            else if (k < 86)
                add_tick(rand16(), rand16(), 1'($urandom), 1'($urandom), 1'b1,
                         (k & 1) ? 16'($urandom_range(820)) : rand16());
            else
                add_tick(rand16(), rand16(), 1'($urandom), 1'($urandom), 1'($urandom),
                         rand16());
        end
    endtask

    task automatic random_regs();
        set_regs(16'($urandom), 16'($urandom), 16'($urandom_range(3000)),
                 16'($urandom_range(32767, 1)), 16'($urandom), 16'($urandom_range(32767)),
                 16'($urandom_range(2000)), 16'($urandom_range(1)));
    endtask

    initial
    begin
        n_fail       = 0;
        src_idle     = 0;
        snk_stall    = 0;
        holdoff_req  = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = pdsc_pkg::CFG_GAIN_P;
        cfg_data     = 16'd0;
        in_ch.valid  = 1'b0;
        in_ch.way_x  = 16'sd0;
        in_ch.way_y  = 16'sd0;
        in_ch.goal_active    = 1'b0;
        in_ch.way_found      = 1'b0;
        in_ch.at_goal        = 1'b0;
        in_ch.measured_speed = 16'sd0;
        out_ch.ready = 1'b0;
        m_gain_p  = pdsc_pkg::RST_GAIN_P;
        m_gain_d  = pdsc_pkg::RST_GAIN_D;
        m_lim     = pdsc_pkg::RST_ERR_LIMIT;
        m_look    = pdsc_pkg::RST_LOOKAHEAD;
        m_neutral = longint'($signed(pdsc_pkg::RST_NEUTRAL));
        m_target  = pdsc_pkg::RST_TARGET;
        m_step    = pdsc_pkg::RST_SPD_STEP;
        m_smooth  = pdsc_pkg::RST_SMOOTH;
        m_prev_err = 0;
        m_speed    = 0;
        m_steer    = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed ticks at reset settings
        add_tick(16'h7fff, 16'h0000, 1'b1, 1'b1, 1'b0, 16'd0);   // zero numerator
        add_tick(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 16'd0);   // zero waypoint
        add_tick(16'h7fff, 16'h7fff, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0, 16'd0);   // most negative waypoint
        add_tick(16'h8000, 16'h7fff, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h0000, 16'h7fff, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h0000, 16'h8000, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h1000, 16'h0800, 1'b0, 1'b1, 1'b0, 16'd0);   // no goal: held
        add_tick(16'h1000, 16'h0800, 1'b1, 1'b0, 1'b0, 16'd0);   // no waypoint: held
        add_tick(16'h1000, 16'h0800, 1'b1, 1'b1, 1'b1, 16'd410); // at goal, braking
        add_tick(16'h1000, 16'h0800, 1'b0, 1'b0, 1'b1, 16'd409); // at goal, stopped
        add_tick(16'h1000, 16'h0800, 1'b1, 1'b1, 1'b1, 16'h7fff);
        add_tick(16'h1000, 16'h0800, 1'b1, 1'b1, 1'b1, 16'h8000);
        add_tick(16'h0001, 16'hffff, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'hffff, 16'h0001, 1'b1, 1'b1, 1'b0, 16'd0);
        wait_idle();

        // zero denominator: lookahead*r == -2*offset*x
        set_regs(16'hffff, 16'hffff, 16'd0, 16'd1000, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0);
        add_tick(16'hfc18, 16'd940, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'hfc18, -16'sd940, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h7fff, 16'h8000, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h8000, 16'h7fff, 1'b1, 1'b1, 1'b0, 16'd0);
        add_tick(16'h0000, 16'h0000, 1'b1, 1'b1, 1'b1, 16'd500);
        wait_idle();

        set_regs(16'd0, 16'd0, 16'h7fff, 16'd1, 16'h8000, 16'd0, 16'd0, 16'd1);
        add_random(150);
        wait_idle();

        set_regs(pdsc_pkg::RST_GAIN_P, pdsc_pkg::RST_GAIN_D, 16'(pdsc_pkg::RST_ERR_LIMIT),
                 16'(pdsc_pkg::RST_LOOKAHEAD), pdsc_pkg::RST_NEUTRAL,
                 16'(pdsc_pkg::RST_TARGET), 16'(pdsc_pkg::RST_SPD_STEP),
                 16'(pdsc_pkg::RST_SMOOTH));
        src_idle = 62;
        add_random(200);
        wait_idle();

        random_regs();
        src_idle  = 0;
        snk_stall = 62;
        add_random(200);
        wait_idle();

        random_regs();
        src_idle  = 28;
        snk_stall = 28;
        add_random(200);
        wait_idle();

        // long receiver hold-off while the sender keeps offering
        random_regs();
        src_idle  = 0;
        snk_stall = 0;
        add_random(200);
        @(posedge clk);
        holdoff_req <= 1;
        wait_idle();

        set_regs(16'hffff, 16'hffff, 16'd1, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'd1);
        src_idle  = 28;
        snk_stall = 28;
        add_random(180);
        wait_idle();

        random_regs();
        src_idle  = 62;
        snk_stall = 62;
        add_random(200);
        wait_idle();

        if (n_fail == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+sv
sv/pdsc_pkg.sv
sv/pdsc_in_if.sv
sv/pdsc_out_if.sv
sv/pdsc_ctrl.sv
sv/pdsc_datapath.sv
sv/pd_steering_speed_control_unit.sv
test/tb.sv
